// ===== rtl/core/ibsc_pkg.sv =====
package ibsc_pkg;

  localparam int NUM_AXES = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;
  localparam int STEP_W   = 7;
  localparam int COUNT_W  = 7;
  localparam int TARGET_W = 15;
  localparam int START_W  = 16;

  typedef enum logic [CFG_AW-1:0] {
    REG_START_ACCEL_X = 3'd0,
    REG_START_ACCEL_Y = 3'd1,
    REG_START_ACCEL_Z = 3'd2,
    REG_Z_TARGET      = 3'd3,
    REG_COARSE_STEP   = 3'd4,
    REG_FINE_STEP     = 3'd5,
    REG_SWITCH_COUNT  = 3'd6,
    REG_TOTAL_COUNT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [START_W-1:0]  start_accel_x;
    logic [START_W-1:0]  start_accel_y;
    logic [START_W-1:0]  start_accel_z;
    logic [TARGET_W-1:0] z_target;
    logic [STEP_W-1:0]   coarse_step;
    logic [STEP_W-1:0]   fine_step;
    logic [COUNT_W-1:0]  switch_count;
    logic [COUNT_W-1:0]  total_count;
  } cfg_t;

  localparam logic [START_W-1:0]  RST_START        = '0;
  localparam logic [TARGET_W-1:0] RST_Z_TARGET     = 15'h4000;
  localparam logic [STEP_W-1:0]   RST_COARSE_STEP  = 7'd10;
  localparam logic [STEP_W-1:0]   RST_FINE_STEP    = 7'd2;
  localparam logic [COUNT_W-1:0]  RST_SWITCH_COUNT = 7'd40;
  localparam logic [COUNT_W-1:0]  RST_TOTAL_COUNT  = 7'd100;

endpackage

// ===== rtl/core/ibsc_cfg.sv =====
module ibsc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ibsc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ibsc_pkg::CFG_DW-1:0]  cfg_wdata,
  output ibsc_pkg::cfg_t               cfg
);
  import ibsc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_accel_x <= RST_START;
      cfg.start_accel_y <= RST_START;
      cfg.start_accel_z <= RST_START;
      cfg.z_target      <= RST_Z_TARGET;
      cfg.coarse_step   <= RST_COARSE_STEP;
      cfg.fine_step     <= RST_FINE_STEP;
      cfg.switch_count  <= RST_SWITCH_COUNT;
      cfg.total_count   <= RST_TOTAL_COUNT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_ACCEL_X: cfg.start_accel_x <= cfg_wdata[START_W-1:0];
        REG_START_ACCEL_Y: cfg.start_accel_y <= cfg_wdata[START_W-1:0];
        REG_START_ACCEL_Z: cfg.start_accel_z <= cfg_wdata[START_W-1:0];
        REG_Z_TARGET:      cfg.z_target      <= cfg_wdata[TARGET_W-1:0];
        REG_COARSE_STEP:   cfg.coarse_step   <= cfg_wdata[STEP_W-1:0];
        REG_FINE_STEP:     cfg.fine_step     <= cfg_wdata[STEP_W-1:0];
        REG_SWITCH_COUNT:  cfg.switch_count  <= cfg_wdata[COUNT_W-1:0];
        REG_TOTAL_COUNT:   cfg.total_count   <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ibsc_in_stage.sv =====
module ibsc_in_stage #(
  parameter int SAMPLE_BITS = 16,
  parameter int DATA_W      = 96
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [DATA_W-1:0]                 s_tdata,
  input  logic                              s_tuser,
  input  logic                              take,
  output logic                              in_valid,
  output logic                              in_begin,
  output logic [5:0][SAMPLE_BITS-1:0]       in_samples
);
  import ibsc_pkg::*;

  logic load;
  logic in_valid_next;

  // the slot frees in the same cycle its beat moves on
  assign s_tready = !in_valid || take;
  assign load     = s_tvalid && s_tready;

  always_comb begin
    in_valid_next = in_valid;
    if (load) begin
      in_valid_next = 1'b1;
    end else if (take) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_begin   <= s_tuser;
      in_samples <= s_tdata[6*SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/ibsc_update.sv =====
module ibsc_update #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ibsc_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  input  logic                              in_begin,
  input  logic [5:0][SAMPLE_BITS-1:0]       in_samples,
  output logic                              take,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [5:0][SAMPLE_BITS-1:0]       offsets,
  output logic                              done
);
  import ibsc_pkg::*;

  localparam int SW = SAMPLE_BITS + 1;
  localparam int CW = ((SAMPLE_BITS > START_W) ? SAMPLE_BITS : START_W) + 1;

  function automatic logic [SAMPLE_BITS-1:0] sat_fn(input logic [SW-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v[SW-1] != v[SW-2]) begin
      r = v[SW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  logic [COUNT_W-1:0]              sample_index, sample_index_next;
  logic                            running, running_next;
  logic [5:0][SAMPLE_BITS-1:0]     offsets_next;
  logic                            done_next;
  logic                            m_tvalid_next;
  logic                            active;
  logic [STEP_W-1:0]               step;
  logic [SW-1:0]                   step_ext;
  logic [2:0]                      acc_up, acc_dn;
  logic signed [CW-1:0]            az_c, tz_c;
  logic [SW-1:0]                   acc_ext [NUM_AXES];
  logic [SW-1:0]                   acc_sum [NUM_AXES];
  logic [SW-1:0]                   gyr_ext [NUM_AXES];
  logic [SW-1:0]                   gyr_sum [NUM_AXES];
  logic [2:0]                      gyr_up, gyr_dn;

  assign take   = in_valid && (!m_tvalid || m_tready);
  assign active = running && (sample_index < cfg.total_count);
  assign step   = (sample_index >= cfg.switch_count) ? cfg.fine_step : cfg.coarse_step;
  assign step_ext = SW'(step);

  // x and y only care about the sign, z about the 1 g target
  assign az_c = CW'($signed(in_samples[2]));
  assign tz_c = CW'(cfg.z_target);

  always_comb begin
    acc_dn[0] = !in_samples[0][SAMPLE_BITS-1] && (in_samples[0] != '0);
    acc_up[0] = in_samples[0][SAMPLE_BITS-1];
    acc_dn[1] = !in_samples[1][SAMPLE_BITS-1] && (in_samples[1] != '0);
    acc_up[1] = in_samples[1][SAMPLE_BITS-1];
    acc_dn[2] = az_c > tz_c;
    acc_up[2] = az_c < tz_c;
    for (int i = 0; i < NUM_AXES; i++) begin
      // gyro dead band is -1..1
      gyr_dn[i] = !in_samples[3+i][SAMPLE_BITS-1] &&
                  (in_samples[3+i][SAMPLE_BITS-1:1] != '0);
      gyr_up[i] = in_samples[3+i][SAMPLE_BITS-1] && (in_samples[3+i] != '1);
      acc_ext[i] = {offsets[i][SAMPLE_BITS-1], offsets[i]};
      gyr_ext[i] = {offsets[3+i][SAMPLE_BITS-1], offsets[3+i]};
      acc_sum[i] = acc_dn[i] ? acc_ext[i] - step_ext : acc_ext[i] + step_ext;
      gyr_sum[i] = gyr_dn[i] ? gyr_ext[i] - SW'(1) : gyr_ext[i] + SW'(1);
    end
  end

  always_comb begin
    offsets_next      = offsets;
    sample_index_next = sample_index;
    running_next      = running;
    if (in_begin) begin
      offsets_next[0]   = SAMPLE_BITS'($signed(cfg.start_accel_x));
      offsets_next[1]   = SAMPLE_BITS'($signed(cfg.start_accel_y));
      offsets_next[2]   = SAMPLE_BITS'($signed(cfg.start_accel_z));
      offsets_next[3]   = '0;
      offsets_next[4]   = '0;
      offsets_next[5]   = '0;
      sample_index_next = '0;
      running_next      = 1'b1;
    end else if (active) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (acc_dn[i] || acc_up[i]) begin
          offsets_next[i] = sat_fn(acc_sum[i]);
        end
        if (gyr_dn[i] || gyr_up[i]) begin
          offsets_next[3+i] = sat_fn(gyr_sum[i]);
        end
      end
      sample_index_next = sample_index + COUNT_W'(1);
    end
    done_next = running_next && (sample_index_next >= cfg.total_count);
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (take) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  // the offset registers double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      offsets      <= '0;
      sample_index <= '0;
      running      <= 1'b0;
      done         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      if (take) begin
        offsets      <= offsets_next;
        sample_index <= sample_index_next;
        running      <= running_next;
        done         <= done_next;
      end
    end
  end

  a_begin_restarts: assert property (@(posedge clk) disable iff (rst)
    take && in_begin |=> running && (sample_index == '0) && (offsets[3] == '0))
    else $error("begin beat did not restart the run");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    !running |-> (sample_index == '0) && !done)
    else $error("sample count moved while idle");

  a_hold_when_no_take: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(offsets) && $stable(sample_index) && $stable(running))
    else $error("state changed without a beat");

  a_gyro_unit_step: assert property (@(posedge clk) disable iff (rst)
    take && !in_begin |=> (offsets[3] == $past(offsets[3])) ||
      (offsets[3] == $past(offsets[3]) + SAMPLE_BITS'(1)) ||
      (offsets[3] == $past(offsets[3]) - SAMPLE_BITS'(1)))
    else $error("gyro x offset moved by more than one");

endmodule

// ===== rtl/core/imu_bias_step_calibrator.sv =====
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | tdata: acc_x..rate_z, tuser: begin_req
// m_       | out | m_tvalid/m_tready  | tdata: acc_off_x..rate_off_z, tuser: done_res
// cfg_     | in  | cfg_we             | cfg_addr, cfg_wdata
//
// one beat per cycle sustained while the output is not stalled; a beat goes
// through the input register and then lands in the offset registers.
// the offset registers themselves form the result register, so a beat is
// taken while a result waits as long as the input register has room.
// rst clears offsets, sample count, run state and both valid flags.
module imu_bias_step_calibrator #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, zero pad
  input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // begin_req
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // acc_off_x, acc_off_y, acc_off_z, rate_off_x, rate_off_y, rate_off_z, zero pad
  output logic [((6*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  // done_res
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [ibsc_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [ibsc_pkg::CFG_DW-1:0]       cfg_wdata
);
  import ibsc_pkg::*;

  localparam int DATA_W = ((6*SAMPLE_BITS+7)/8)*8;

  cfg_t                         cfg;
  logic                         take;
  logic                         in_valid;
  logic                         in_begin;
  logic [5:0][SAMPLE_BITS-1:0]  in_samples;
  logic [5:0][SAMPLE_BITS-1:0]  offsets;

  ibsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ibsc_in_stage #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DATA_W      (DATA_W)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (take),
    .in_valid   (in_valid),
    .in_begin   (in_begin),
    .in_samples (in_samples)
  );

  ibsc_update #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_begin   (in_begin),
    .in_samples (in_samples),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .offsets    (offsets),
    .done       (m_tuser)
  );

  assign m_tdata = DATA_W'(offsets);

endmodule

// ===== test/tb_imu_bias_step_calibrator.sv =====
`timescale 1ns / 1ps
module tb_imu_bias_step_calibrator;
  import ibsc_pkg::*;

  localparam int LIMIT = 300000;

  typedef struct packed {
    logic        beg;
    logic [95:0] data;
  } sample_t;

  typedef struct packed {
    logic        done;
    logic [95:0] data;
  } offsets_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z
  logic [95:0] s_tdata = '0;
  // begin_req
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // acc_off_x, acc_off_y, acc_off_z, rate_off_x, rate_off_y, rate_off_z
  logic [95:0] m_tdata;
  // done_res
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_addr = REG_START_ACCEL_X;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  sample_t  pending_samples[$];
  offsets_t expected_offsets[$];

  // calibrator state as the testbench sees it
  cfg_t       cal_cfg;
  int         acc_off[3];
  int         rate_off[3];
  logic [6:0] sample_idx;
  bit         running;

  bit  beat_taken;
  bit  phase_idle = 1'b1;
  bit  calm = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  errors = 0;
  int  cycles = 0;
  int  queued_items = 0;
  string field_name[6] = '{"acc_off_x", "acc_off_y", "acc_off_z",
                           "rate_off_x", "rate_off_y", "rate_off_z"};

  imu_bias_step_calibrator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic offsets_t calibrate(sample_t s);
    offsets_t r;
    int step, thr, rd, k;
    if (s.beg) begin
      acc_off[0] = int'($signed(cal_cfg.start_accel_x));
      acc_off[1] = int'($signed(cal_cfg.start_accel_y));
      acc_off[2] = int'($signed(cal_cfg.start_accel_z));
      for (k = 0; k < 3; k++) rate_off[k] = 0;
      sample_idx = '0;
      running = 1'b1;
    end else if (running && sample_idx < cal_cfg.total_count) begin
      step = (sample_idx >= cal_cfg.switch_count) ? int'(cal_cfg.fine_step)
                                                  : int'(cal_cfg.coarse_step);
      for (k = 0; k < 3; k++) begin
        // z is steered towards the 1 g reading, x and y towards zero
        thr = (k == 2) ? int'(cal_cfg.z_target) : 0;
        rd = int'($signed(s.data[16*k +: 16]));
        if (rd > thr) acc_off[k] = clamp16(acc_off[k] - step);
        else if (rd < thr) acc_off[k] = clamp16(acc_off[k] + step);
        rd = int'($signed(s.data[16*(k+3) +: 16]));
        if (rd > 1) rate_off[k] = clamp16(rate_off[k] - 1);
        else if (rd < -1) rate_off[k] = clamp16(rate_off[k] + 1);
      end
      sample_idx = sample_idx + 7'd1;
    end
    for (k = 0; k < 3; k++) begin
      r.data[16*k +: 16] = acc_off[k][15:0];
      r.data[16*(k+3) +: 16] = rate_off[k][15:0];
    end
    r.done = running && (sample_idx >= cal_cfg.total_count);
    return r;
  endfunction

  // accepted input beats feed the prediction
  always @(posedge clk) begin
    beat_taken = s_tvalid && s_tready && !rst;
    if (beat_taken) expected_offsets.push_back(calibrate({s_tuser, s_tdata}));
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || beat_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        {s_tuser, s_tdata} <= pending_samples.pop_front();
        s_tvalid <= 1'b1;
        if (phase_idle && !calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (phase_idle && !calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin : monitor
    offsets_t exp_off;
    int k;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_offsets.size() == 0) begin
        $display("%0t: unexpected result beat, actual tdata %h done %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_off = expected_offsets.pop_front();
        for (k = 0; k < 6; k++) begin
          if (m_tdata[16*k +: 16] !== exp_off.data[16*k +: 16]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name[k],
                     $signed(exp_off.data[16*k +: 16]), $signed(m_tdata[16*k +: 16]));
            errors++;
          end
        end
        if (m_tuser !== exp_off.done) begin
          $display("%0t: done_res mismatch, expected %b, actual %b", $time, exp_off.done, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_sample(bit beg, int ax, int ay, int az, int rx, int ry, int rz);
    sample_t s;
    s.beg = beg;
    s.data = {rz[15:0], ry[15:0], rx[15:0], az[15:0], ay[15:0], ax[15:0]};
    pending_samples.push_back(s);
    queued_items++;
  endtask

  task automatic program_reg(cfg_reg_t r, logic [15:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = r;
    cfg_wdata = v;
    case (r)
      REG_START_ACCEL_X: cal_cfg.start_accel_x = v;
      REG_START_ACCEL_Y: cal_cfg.start_accel_y = v;
      REG_START_ACCEL_Z: cal_cfg.start_accel_z = v;
      REG_Z_TARGET:      cal_cfg.z_target = v[TARGET_W-1:0];
      REG_COARSE_STEP:   cal_cfg.coarse_step = v[STEP_W-1:0];
      REG_FINE_STEP:     cal_cfg.fine_step = v[STEP_W-1:0];
      REG_SWITCH_COUNT:  cal_cfg.switch_count = v[COUNT_W-1:0];
      REG_TOTAL_COUNT:   cal_cfg.total_count = v[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // holds off until the block has drained every outstanding beat
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_offsets.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic int pick_reading(int centre);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 65535));
      1: return centre + int'($urandom_range(0, 6)) - 3;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return centre;
    endcase
  endfunction

  function automatic logic [15:0] pick_start();
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd127;
      default: return 16'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic randomise_config();
    int total;
    case ($urandom_range(0, 7))
      0: total = 127;
      1: total = 1;
      default: total = $urandom_range(2, 30);
    endcase
    program_reg(REG_START_ACCEL_X, pick_start());
    program_reg(REG_START_ACCEL_Y, pick_start());
    program_reg(REG_START_ACCEL_Z, pick_start());
    case ($urandom_range(0, 3))
      0: program_reg(REG_Z_TARGET, 16'h0000);
      1: program_reg(REG_Z_TARGET, 16'h7FFF);
      default: program_reg(REG_Z_TARGET, 16'($urandom_range(0, 65535)));
    endcase
    program_reg(REG_COARSE_STEP, pick_step());
    program_reg(REG_FINE_STEP, pick_step());
    program_reg(REG_SWITCH_COUNT, (total + 3 > 127) ? 16'($urandom_range(0, 127))
                                                    : 16'($urandom_range(0, total + 3)));
    program_reg(REG_TOTAL_COUNT, 16'(total));
  endtask

  task automatic add_random_sample();
    int tz;
    tz = int'(cal_cfg.z_target);
    add_sample($urandom_range(0, 15) == 0, pick_reading(0), pick_reading(0), pick_reading(tz),
               pick_reading(0), pick_reading(0), pick_reading(0));
  endtask

  initial begin
    int runs, n;
    cal_cfg = '{RST_START, RST_START, RST_START, RST_Z_TARGET, RST_COARSE_STEP,
                RST_FINE_STEP, RST_SWITCH_COUNT, RST_TOTAL_COUNT};
    for (int k = 0; k < 3; k++) begin
      acc_off[k] = 0;
      rate_off[k] = 0;
    end
    sample_idx = '0;
    running = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: samples before any begin, thresholds, dead band, restart mid-run
    add_sample(0, -32768, -32768, -32768, -32768, -32768, -32768);
    add_sample(0, 32767, 32767, 32767, 32767, 32767, 32767);
    add_sample(1, -1, -1, -1, -1, -1, -1);
    add_sample(0, 32767, -32768, 16384, 2, -2, 1);
    add_sample(0, 1, -1, 16385, -1, 0, 32767);
    add_sample(0, 0, 0, 16383, -32768, 1, -1);
    add_sample(0, 5, -7, -32768, 0, 32767, -2);
    add_sample(0, -3, 3, 32767, 3, -3, 0);
    add_sample(1, 12345, -4321, 999, 42, -42, 7);
    add_sample(0, 100, 100, 100, 100, 100, 100);
    wait_drained();

    // saturating starts with a huge coarse step, zero fine step and a short run
    program_reg(REG_START_ACCEL_X, 16'h7FFF);
    program_reg(REG_START_ACCEL_Y, 16'h8000);
    program_reg(REG_START_ACCEL_Z, 16'h8000);
    program_reg(REG_Z_TARGET, 16'h0000);
    program_reg(REG_COARSE_STEP, 16'd127);
    program_reg(REG_FINE_STEP, 16'd0);
    program_reg(REG_SWITCH_COUNT, 16'd1);
    program_reg(REG_TOTAL_COUNT, 16'd3);
    add_sample(1, 0, 0, 0, 0, 0, 0);
    add_sample(0, -1, 1, -1, 2, 2, -2);
    add_sample(0, -1, 1, 0, 2, -2, 2);
    add_sample(0, 32767, -32768, 1, -32768, 32767, 0);
    add_sample(0, 1, 1, 1, 9, 9, 9);
    add_sample(0, -1, -1, -1, -9, -9, -9);
    wait_drained();

    // zero run length, zero coarse step, switch count above the run
    program_reg(REG_Z_TARGET, 16'h7FFF);
    program_reg(REG_COARSE_STEP, 16'd0);
    program_reg(REG_SWITCH_COUNT, 16'd127);
    program_reg(REG_TOTAL_COUNT, 16'd0);
    add_sample(1, 0, 0, 0, 0, 0, 0);
    add_sample(0, 32767, -32768, 32767, 5, -5, 5);
    add_sample(0, -32768, 32767, -32768, -5, 5, -5);
    wait_drained();

    while (queued_items < 880) begin
      randomise_config();
      phase_idle = $urandom_range(0, 3) != 0;
      if (queued_items > 760) calm = 1'b1;
      runs = $urandom_range(1, 3);
      repeat (runs) begin
        add_sample(1, pick_reading(0), pick_reading(0), pick_reading(0),
                   pick_reading(0), pick_reading(0), pick_reading(0));
        n = cal_cfg.total_count + $urandom_range(0, 4);
        // now and then a run is cut short by the next begin
        if ($urandom_range(0, 5) == 0) n = $urandom_range(0, cal_cfg.total_count);
        repeat (n) add_random_sample();
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
